// ===== rtl/stack_queue_common_key_finder_macros.svh =====
// Assertion macros used by the datapath of the common-key finder.
// Each macro checks an implication sampled at the rising clock edge and is
// disabled while reset is held.
`ifndef STACK_QUEUE_COMMON_KEY_FINDER_MACROS_SVH
`define STACK_QUEUE_COMMON_KEY_FINDER_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define SQCKF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Consequent must hold in the cycle after the antecedent.
`define SQCKF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define SQCKF_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SQCKF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/sqckf_pkg.sv =====
package sqckf_pkg;

    localparam int KEY_W     = 18;
    localparam int POS_W     = 4;
    localparam int CMD_W     = 2;
    localparam int DEPTH_DEF = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_ENQ  = 2'd1,
        CMD_RUN  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push;
        logic enq;
        logic scan_start;
        logic scan_step;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pair_match;
        logic pair_last;
        logic stores_empty;
        logic pend_valid;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/sqckf_channels.sv =====
interface sqckf_in_if;
    logic                              valid;
    logic                              ready;
    logic [sqckf_pkg::CMD_W-1:0]       cmd;
    logic signed [sqckf_pkg::KEY_W-1:0] key;

    modport source (output valid, output cmd, output key, input ready);
    modport sink (input valid, input cmd, input key, output ready);
endinterface

interface sqckf_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [sqckf_pkg::KEY_W-1:0] match_key;
    logic [sqckf_pkg::POS_W-1:0]       stack_pos;
    logic [sqckf_pkg::POS_W-1:0]       queue_pos;
    logic                              match_valid;
    logic                              overflow;
    logic                              last;

    modport source (output valid, output match_key, output stack_pos, output queue_pos,
                    output match_valid, output overflow, output last, input ready);
    modport sink (input valid, input match_key, input stack_pos, input queue_pos,
                  input match_valid, input overflow, input last, output ready);
endinterface

// ===== rtl/sqckf_ctrl.sv =====
module sqckf_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [sqckf_pkg::CMD_W-1:0] in_cmd,
    output logic                        in_ready,
    input  sqckf_pkg::dp_stat_t         stat,
    output sqckf_pkg::dp_cmd_t          cmd
);

    sqckf_pkg::state_t state_reg;
    sqckf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sqckf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            sqckf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (in_cmd)
                        sqckf_pkg::CMD_PUSH: cmd.push = 1'b1;
                        sqckf_pkg::CMD_ENQ:  cmd.enq  = 1'b1;
                        sqckf_pkg::CMD_RUN:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next = stat.stores_empty ? sqckf_pkg::ST_FINISH
                                                           : sqckf_pkg::ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            sqckf_pkg::ST_SCAN:
            begin
                // A match with a result already pending needs the output slot.
                if (!(stat.pair_match && stat.pend_valid) || stat.out_free)
                begin
                    cmd.scan_step = 1'b1;
                    if (stat.pair_last)
                    begin
                        state_next = sqckf_pkg::ST_FINISH;
                    end
                end
            end
            sqckf_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = sqckf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sqckf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/sqckf_dp.sv =====
`include "stack_queue_common_key_finder_macros.svh"

module sqckf_dp
#(
    parameter int DEPTH = sqckf_pkg::DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  sqckf_pkg::dp_cmd_t                 cmd,
    input  logic signed [sqckf_pkg::KEY_W-1:0] key,
    output sqckf_pkg::dp_stat_t                stat,
    sqckf_out_if.source                        results
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [sqckf_pkg::KEY_W-1:0] stack_keys_reg [DEPTH];
    logic signed [sqckf_pkg::KEY_W-1:0] queue_keys_reg [DEPTH];
    logic [CNT_W-1:0] stack_count_reg;
    logic [CNT_W-1:0] queue_count_reg;
    logic             overflow_reg;

    logic [IDX_W-1:0] s_reg;
    logic [IDX_W-1:0] q_reg;

    // Match held back until it is known whether it is the last of the run.
    logic                               pend_valid_reg;
    logic signed [sqckf_pkg::KEY_W-1:0] pend_key_reg;
    logic [sqckf_pkg::POS_W-1:0]        pend_spos_reg;
    logic [sqckf_pkg::POS_W-1:0]        pend_qpos_reg;

    logic                               out_valid_reg;
    logic signed [sqckf_pkg::KEY_W-1:0] out_key_reg;
    logic [sqckf_pkg::POS_W-1:0]        out_spos_reg;
    logic [sqckf_pkg::POS_W-1:0]        out_qpos_reg;
    logic                               out_match_reg;
    logic                               out_ovf_reg;
    logic                               out_last_reg;

    logic [IDX_W-1:0]                   stack_addr;
    logic signed [sqckf_pkg::KEY_W-1:0] stack_key;
    logic signed [sqckf_pkg::KEY_W-1:0] queue_key;
    logic                               q_end;
    logic                               s_end;
    logic                               stack_full;
    logic                               queue_full;
    logic                               out_free;
    logic                               emit_step;
    logic                               load_out;

    assign stack_addr = IDX_W'(stack_count_reg - CNT_W'(1) - CNT_W'(s_reg));
    assign stack_key  = stack_keys_reg[stack_addr];
    assign queue_key  = queue_keys_reg[q_reg];
    assign q_end      = (CNT_W'(q_reg) == (queue_count_reg - CNT_W'(1)));
    assign s_end      = (CNT_W'(s_reg) == (stack_count_reg - CNT_W'(1)));
    assign stack_full = (stack_count_reg >= CNT_W'(DEPTH));
    assign queue_full = (queue_count_reg >= CNT_W'(DEPTH));
    assign out_free   = !out_valid_reg || results.ready;

    assign stat.pair_match   = (stack_key == queue_key);
    assign stat.pair_last    = s_end && q_end;
    assign stat.stores_empty = (stack_count_reg == '0) || (queue_count_reg == '0);
    assign stat.pend_valid   = pend_valid_reg;
    assign stat.out_free     = out_free;

    assign emit_step = cmd.scan_step && stat.pair_match && pend_valid_reg;
    assign load_out  = emit_step || cmd.finish;

    always_ff @(posedge clk)
    begin
        if (cmd.push && !stack_full)
        begin
            stack_keys_reg[stack_count_reg[IDX_W-1:0]] <= key;
        end
        if (cmd.enq && !queue_full)
        begin
            queue_keys_reg[queue_count_reg[IDX_W-1:0]] <= key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_count_reg <= '0;
            queue_count_reg <= '0;
            overflow_reg    <= 1'b0;
        end
        else if (cmd.finish)
        begin
            stack_count_reg <= '0;
            queue_count_reg <= '0;
            overflow_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.push)
            begin
                if (stack_full)
                begin
                    overflow_reg <= 1'b1;
                end
                else
                begin
                    stack_count_reg <= stack_count_reg + CNT_W'(1);
                end
            end
            if (cmd.enq)
            begin
                if (queue_full)
                begin
                    overflow_reg <= 1'b1;
                end
                else
                begin
                    queue_count_reg <= queue_count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg          <= '0;
            q_reg          <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.scan_start || cmd.finish)
        begin
            s_reg          <= '0;
            q_reg          <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            if (q_end)
            begin
                q_reg <= '0;
                s_reg <= s_reg + IDX_W'(1);
            end
            else
            begin
                q_reg <= q_reg + IDX_W'(1);
            end
            if (stat.pair_match)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && stat.pair_match)
        begin
            pend_key_reg  <= stack_key;
            pend_spos_reg <= sqckf_pkg::POS_W'(s_reg) + sqckf_pkg::POS_W'(1);
            pend_qpos_reg <= sqckf_pkg::POS_W'(q_reg) + sqckf_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_ovf_reg <= overflow_reg;
            if (pend_valid_reg)
            begin
                out_key_reg   <= pend_key_reg;
                out_spos_reg  <= pend_spos_reg;
                out_qpos_reg  <= pend_qpos_reg;
                out_match_reg <= 1'b1;
            end
            else
            begin
                out_key_reg   <= '0;
                out_spos_reg  <= '0;
                out_qpos_reg  <= '0;
                out_match_reg <= 1'b0;
            end
            out_last_reg <= cmd.finish;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.match_key   = out_key_reg;
    assign results.stack_pos   = out_spos_reg;
    assign results.queue_pos   = out_qpos_reg;
    assign results.match_valid = out_match_reg;
    assign results.overflow    = out_ovf_reg;
    assign results.last        = out_last_reg;

    `SQCKF_ASSERT_NEXT(a_finish_clears, clk, rst_n, cmd.finish,
        (stack_count_reg == '0) && (queue_count_reg == '0) && !overflow_reg)
    `SQCKF_ASSERT_SAME(a_no_overwrite, clk, rst_n, load_out, out_free)
    `SQCKF_ASSERT_SAME(a_step_nonempty, clk, rst_n, cmd.scan_step, !stat.stores_empty)
    `SQCKF_ASSERT_NEXT(a_finish_last, clk, rst_n, cmd.finish,
        results.valid && results.last && (results.match_valid || !$past(pend_valid_reg)))

endmodule

// ===== rtl/stack_queue_common_key_finder.sv =====
// Stack and queue common-key finder. Command 0 pushes the key onto an
// internal stack and command 1 appends it to an internal queue, each holding
// up to DEPTH keys; a load into a full store is dropped and sets a sticky
// overflow flag. Command 2 runs a match: the stack is walked from its top,
// and for every stack entry the queue is walked from its front, one
// stack/queue pair compared per clock cycle by a single comparator unless a
// new match waits for a full result register. Each equal pair yields one
// result item with the key and both 1-based positions; a run with no equal
// pair yields a single item with match_valid clear. The final item of a run
// has last set, every item of a run carries the overflow flag, and the run
// then empties both stores and clears the flag. Loads are accepted back to
// back while idle. The input is held off for the whole run, which may also
// stall while the result register is full and not taken.
// Command 3 is accepted and ignored. Stored keys are not cleared at reset;
// only entries below the counts are ever read.
module stack_queue_common_key_finder
#(
    parameter int DEPTH = sqckf_pkg::DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    sqckf_in_if.sink    items,
    sqckf_out_if.source results
);

    sqckf_pkg::dp_cmd_t  cmd;
    sqckf_pkg::dp_stat_t stat;

    // The controller sequences loads, the pair walk and the end of a run.
    sqckf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_cmd   (items.cmd),
        .in_ready (items.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds both stores, the walk counters, the pending match
    // and the result register.
    sqckf_dp
    #(
        .DEPTH (DEPTH)
    )
    u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .key     (items.key),
        .stat    (stat),
        .results (results)
    );

endmodule
